>>> sv/stok_pkg.sv
// Shared types and constants for the source tokenizer.
`default_nettype none
package stok_pkg;

	localparam int POS_BITS  = 32;
	localparam int SPAN_BITS = 16;
	localparam int KIND_BITS = 5;
	localparam int KWI_BITS  = 2;
	localparam int KW_COUNT  = 3;

	localparam int LEN_BITS   = (POS_BITS + 1 > SPAN_BITS) ? POS_BITS + 1 : SPAN_BITS;
	localparam int FIELD_BITS = KIND_BITS + POS_BITS + SPAN_BITS + KWI_BITS;
	localparam int TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;

	localparam int Q_DEPTH  = 4;
	localparam int PTR_BITS = $clog2(Q_DEPTH);
	localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

	localparam logic [SPAN_BITS-1:0] SPAN_MAX = '1;

	// token kinds
	localparam logic [KIND_BITS-1:0] K_EOF       = 5'd0;
	localparam logic [KIND_BITS-1:0] K_INT       = 5'd1;
	localparam logic [KIND_BITS-1:0] K_KEYWORD   = 5'd2;
	localparam logic [KIND_BITS-1:0] K_IDENT     = 5'd3;
	localparam logic [KIND_BITS-1:0] K_PLUS      = 5'd4;
	localparam logic [KIND_BITS-1:0] K_MINUS     = 5'd5;
	localparam logic [KIND_BITS-1:0] K_SLASH     = 5'd6;
	localparam logic [KIND_BITS-1:0] K_STAR      = 5'd7;
	localparam logic [KIND_BITS-1:0] K_COLON     = 5'd8;
	localparam logic [KIND_BITS-1:0] K_COLON2    = 5'd9;
	localparam logic [KIND_BITS-1:0] K_EQUAL     = 5'd10;
	localparam logic [KIND_BITS-1:0] K_ASSIGN    = 5'd11;
	localparam logic [KIND_BITS-1:0] K_SEMI      = 5'd12;
	localparam logic [KIND_BITS-1:0] K_LBRACE    = 5'd13;
	localparam logic [KIND_BITS-1:0] K_RBRACE    = 5'd14;
	localparam logic [KIND_BITS-1:0] K_LPAREN    = 5'd15;
	localparam logic [KIND_BITS-1:0] K_RPAREN    = 5'd16;
	localparam logic [KIND_BITS-1:0] K_COMMA     = 5'd17;
	localparam logic [KIND_BITS-1:0] K_BAD_CHAR  = 5'd18;
	localparam logic [KIND_BITS-1:0] K_BAD_PUNCT = 5'd19;

	// keyword indexes
	localparam logic [KWI_BITS-1:0] KW_RETURN = 2'd0;
	localparam logic [KWI_BITS-1:0] KW_RET    = 2'd1;
	localparam logic [KWI_BITS-1:0] KW_INT    = 2'd2;
	localparam logic [KWI_BITS-1:0] KW_NONE   = 2'd3;

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd3, 3'd3};

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [POS_BITS-1:0]  start;
		logic [SPAN_BITS-1:0] span;
		logic [KWI_BITS-1:0]  kwi;
		logic                 last;
	} result_t;

	// up to two results produced by one scanned item, lead first
	typedef struct packed {
		logic [1:0] cnt;
		result_t    lead;
		result_t    tail;
	} push_t;

endpackage
`default_nettype wire

>>> sv/stok_scan.sv
// Scanner state and the per-byte tokenizing step.
`default_nettype none
module stok_scan (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] byte_in,
	input  wire logic       eoi,
	output stok_pkg::push_t push
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_INT,
		M_WORD,
		M_COLON
	} mode_t;

	mode_t                             mode_q, mode_d;
	logic [stok_pkg::POS_BITS-1:0]     pos_q, pos_d;
	logic [stok_pkg::POS_BITS-1:0]     tok_start_q, tok_start_d;
	logic [stok_pkg::POS_BITS-1:0]     last_digit_q, last_digit_d;
	logic [stok_pkg::SPAN_BITS-1:0]    word_len_q, word_len_d;
	logic [stok_pkg::KW_COUNT-1:0]     hits_q, hits_d;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [stok_pkg::KIND_BITS-1:0] punct_kind(input logic [7:0] c);
		logic is_punct;
		is_punct = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
		if (!is_punct) begin
			return stok_pkg::K_BAD_CHAR;
		end
		case (c)
			"+":     return stok_pkg::K_PLUS;
			"-":     return stok_pkg::K_MINUS;
			"/":     return stok_pkg::K_SLASH;
			"*":     return stok_pkg::K_STAR;
			"=":     return stok_pkg::K_EQUAL;
			";":     return stok_pkg::K_SEMI;
			"{":     return stok_pkg::K_LBRACE;
			"}":     return stok_pkg::K_RBRACE;
			"(":     return stok_pkg::K_LPAREN;
			")":     return stok_pkg::K_RPAREN;
			",":     return stok_pkg::K_COMMA;
			default: return stok_pkg::K_BAD_PUNCT;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		case ({k, i})
			{stok_pkg::KW_RETURN, 3'd0}: return "r";
			{stok_pkg::KW_RETURN, 3'd1}: return "e";
			{stok_pkg::KW_RETURN, 3'd2}: return "t";
			{stok_pkg::KW_RETURN, 3'd3}: return "u";
			{stok_pkg::KW_RETURN, 3'd4}: return "r";
			{stok_pkg::KW_RETURN, 3'd5}: return "n";
			{stok_pkg::KW_RET, 3'd0}:    return "r";
			{stok_pkg::KW_RET, 3'd1}:    return "e";
			{stok_pkg::KW_RET, 3'd2}:    return "t";
			{stok_pkg::KW_INT, 3'd0}:    return "i";
			{stok_pkg::KW_INT, 3'd1}:    return "n";
			{stok_pkg::KW_INT, 3'd2}:    return "t";
			default:                     return 8'h00;
		endcase
	endfunction

	// keywords that still match with character c at offset idx
	function automatic logic [stok_pkg::KW_COUNT-1:0] hit_mask(
		input logic [stok_pkg::SPAN_BITS-1:0] idx, input logic [7:0] c);
		logic [stok_pkg::KW_COUNT-1:0] m;
		for (int k = 0; k < stok_pkg::KW_COUNT; k++) begin
			m[k] = (idx < stok_pkg::SPAN_BITS'(stok_pkg::KW_LEN[k])) &&
				(kw_char(2'(k), idx[2:0]) == c);
		end
		return m;
	endfunction

	logic [stok_pkg::POS_BITS-1:0] int_diff;
	logic [stok_pkg::LEN_BITS-1:0] int_len;
	logic [stok_pkg::SPAN_BITS-1:0] int_span;
	logic [stok_pkg::KWI_BITS-1:0] found;
	stok_pkg::result_t flush_r, lead_r, idle_r;
	logic lead_v, idle_v, consumed;

	assign int_diff = last_digit_q - tok_start_q;
	assign int_len  = stok_pkg::LEN_BITS'(int_diff) + stok_pkg::LEN_BITS'(1);
	assign int_span = (int_len > stok_pkg::LEN_BITS'(stok_pkg::SPAN_MAX)) ?
		stok_pkg::SPAN_MAX : int_len[stok_pkg::SPAN_BITS-1:0];

	always_comb begin
		found = stok_pkg::KW_NONE;
		for (int k = stok_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (hits_q[k] && word_len_q == stok_pkg::SPAN_BITS'(stok_pkg::KW_LEN[k])) begin
				found = 2'(k);
			end
		end
	end

	// token pending from the current mode
	always_comb begin
		flush_r       = '0;
		flush_r.start = tok_start_q;
		flush_r.kwi   = stok_pkg::KW_NONE;
		case (mode_q)
			M_INT: begin
				flush_r.kind = stok_pkg::K_INT;
				flush_r.span = int_span;
			end
			M_WORD: begin
				flush_r.kind = (found == stok_pkg::KW_NONE) ? stok_pkg::K_IDENT :
					stok_pkg::K_KEYWORD;
				flush_r.span = word_len_q;
				flush_r.kwi  = found;
			end
			M_COLON: begin
				flush_r.kind = stok_pkg::K_COLON;
				flush_r.span = stok_pkg::SPAN_BITS'(1);
			end
			default: flush_r.kind = stok_pkg::K_EOF;
		endcase
	end

	always_comb begin
		mode_d       = mode_q;
		pos_d        = pos_q;
		tok_start_d  = tok_start_q;
		last_digit_d = last_digit_q;
		word_len_d   = word_len_q;
		hits_d       = hits_q;
		lead_v       = 1'b0;
		lead_r       = flush_r;
		idle_v       = 1'b0;
		consumed     = 1'b0;
		idle_r       = '0;
		idle_r.kind  = punct_kind(byte_in);
		idle_r.start = pos_q;
		idle_r.span  = stok_pkg::SPAN_BITS'(1);
		idle_r.kwi   = stok_pkg::KW_NONE;

		if (eoi) begin
			lead_v       = (mode_q != M_IDLE);
			idle_v       = 1'b1;
			idle_r.kind  = stok_pkg::K_EOF;
			idle_r.span  = '0;
			mode_d       = M_IDLE;
			pos_d        = '0;
			tok_start_d  = '0;
			last_digit_d = '0;
			word_len_d   = '0;
			hits_d       = '1;
		end else begin
			case (mode_q)
				M_INT: begin
					if (is_digit(byte_in)) begin
						last_digit_d = pos_q;
						consumed     = 1'b1;
					end else if (is_space(byte_in)) begin
						consumed = 1'b1;
					end else begin
						lead_v = 1'b1;
					end
				end
				M_WORD: begin
					if (is_alpha(byte_in) || is_digit(byte_in) || byte_in == "_") begin
						hits_d   = hits_q & hit_mask(word_len_q, byte_in);
						consumed = 1'b1;
						if (word_len_q != stok_pkg::SPAN_MAX) begin
							word_len_d = word_len_q + stok_pkg::SPAN_BITS'(1);
						end
					end else begin
						lead_v = 1'b1;
					end
				end
				M_COLON: begin
					lead_v = 1'b1;
					if (byte_in == ":" || byte_in == "=") begin
						lead_r.kind = (byte_in == ":") ? stok_pkg::K_COLON2 :
							stok_pkg::K_ASSIGN;
						lead_r.span = stok_pkg::SPAN_BITS'(2);
						consumed    = 1'b1;
					end
				end
				default: ;
			endcase
			if (lead_v) begin
				mode_d = M_IDLE;
			end
			// rescan the byte from idle when the mode did not take it
			if (!consumed && !is_space(byte_in)) begin
				if (is_digit(byte_in)) begin
					mode_d       = M_INT;
					tok_start_d  = pos_q;
					last_digit_d = pos_q;
				end else if (is_alpha(byte_in)) begin
					mode_d      = M_WORD;
					tok_start_d = pos_q;
					word_len_d  = stok_pkg::SPAN_BITS'(1);
					hits_d      = hit_mask('0, byte_in);
				end else if (byte_in == ":") begin
					mode_d      = M_COLON;
					tok_start_d = pos_q;
				end else begin
					idle_v = 1'b1;
				end
			end
			pos_d = pos_q + stok_pkg::POS_BITS'(1);
		end
	end

	// pack results in order and mark the final one
	always_comb begin
		push = '0;
		if (lead_v) begin
			push.lead      = lead_r;
			push.lead.last = !idle_v;
			push.tail      = idle_r;
			push.tail.last = 1'b1;
			push.cnt       = idle_v ? 2'd2 : 2'd1;
		end else begin
			push.lead      = idle_r;
			push.lead.last = 1'b1;
			push.tail      = idle_r;
			push.cnt       = idle_v ? 2'd1 : 2'd0;
		end
		if (!go) begin
			push.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			pos_q        <= '0;
			tok_start_q  <= '0;
			last_digit_q <= '0;
			word_len_q   <= '0;
			hits_q       <= '1;
		end else if (go) begin
			mode_q       <= mode_d;
			pos_q        <= pos_d;
			tok_start_q  <= tok_start_d;
			last_digit_q <= last_digit_d;
			word_len_q   <= word_len_d;
			hits_q       <= hits_d;
		end
	end

	a_eoi_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		go && eoi |=> pos_q == '0 && mode_q == M_IDLE)
		else $error("end item did not restart the scanner");

endmodule
`default_nettype wire

>>> sv/stok_outq.sv
// Result queue between the scanner and the output stream.
`default_nettype none
module stok_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  stok_pkg::push_t          push,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output stok_pkg::result_t        out_res
);

	stok_pkg::result_t mem_q [stok_pkg::Q_DEPTH];
	logic [stok_pkg::PTR_BITS-1:0] wr_q, rd_q;
	logic [stok_pkg::CNT_BITS-1:0] count_q;
	logic pop;

	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// room for the worst case of two results from one item
	assign room      = (count_q <= stok_pkg::CNT_BITS'(stok_pkg::Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.lead;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + stok_pkg::PTR_BITS'(1)] <= push.tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + stok_pkg::PTR_BITS'(push.cnt);
			rd_q    <= rd_q + stok_pkg::PTR_BITS'(pop);
			count_q <= count_q + stok_pkg::CNT_BITS'(push.cnt) - stok_pkg::CNT_BITS'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= stok_pkg::CNT_BITS'(stok_pkg::Q_DEPTH))
		else $error("result queue overflow");

	a_pair_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> count_q <= stok_pkg::CNT_BITS'(stok_pkg::Q_DEPTH - 2))
		else $error("result pair pushed without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.cnt == 2'd0 |=> count_q == $past(count_q) - stok_pkg::CNT_BITS'(1))
		else $error("queue count did not drop on a lone pop");

endmodule
`default_nettype wire

>>> sv/source_tokenizer.sv
// Source tokenizer top level: input register, scanner and result queue.
// One source byte per clock: a byte transfer is registered, then scanned
// against the current token state once the queue has room, and its results
// (none, one or two) land in a four-entry result queue that drives the
// output stream. Input is taken every cycle as long as the queue has room
// for two results, so throughput is one byte per cycle while the output
// keeps pace; a byte that closes a token and is itself a one-byte token
// yields two results. Results pass the input register, then the queue.
// An item with s_axis_tuser high marks end of input: the pending
// token is flushed, an EOF token follows and the position restarts at zero.
// m_axis_tlast is set on the final result caused by each input item.
`default_nettype none
module source_tokenizer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // byte_req
	input  wire logic                            s_axis_tuser,  // end_of_input
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// kind, start_res, span, keyword_index, zero pad
	output logic [stok_pkg::TDATA_BITS-1:0]      m_axis_tdata,
	output logic                                 m_axis_tlast
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       room;
	logic       go;
	stok_pkg::push_t   push;
	stok_pkg::result_t out_res;

	assign go            = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tuser;
		end
	end

	stok_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.byte_in (byte_s1),
		.eoi     (eoi_s1),
		.push    (push)
	);

	stok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = stok_pkg::TDATA_BITS'({out_res.kwi, out_res.span, out_res.start,
		out_res.kind});
	assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

>>> test/source_tokenizer_checker.sv
// Checker for the source tokenizer: predicts the token stream and compares it.
module source_tokenizer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // byte_req
	input  logic                           s_axis_tuser,  // end_of_input
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// kind, start_res, span, keyword_index, zero pad
	input  logic [stok_pkg::TDATA_BITS-1:0] m_axis_tdata,
	input  logic                           m_axis_tlast,
	output int                             mismatches,
	output int                             pending,
	output int                             tokens_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import stok_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_INT, SCAN_WORD, SCAN_COLON} scan_mode_e;

	scan_mode_e           mode;
	logic [POS_BITS-1:0]  tok_start;
	logic [POS_BITS-1:0]  last_digit;
	logic [POS_BITS-1:0]  pos;
	logic [SPAN_BITS-1:0] word_len;
	logic [KW_COUNT-1:0]  kw_hits;

	result_t expected_tokens[$];
	result_t step_toks[2];
	int      step_n;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"/": return K_SLASH;
			"*": return K_STAR;
			"=": return K_EQUAL;
			";": return K_SEMI;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			",": return K_COMMA;
			default: return K_BAD_PUNCT;
		endcase
	endfunction

	function automatic int kw_length(input int k);
		return (k == KW_RETURN) ? 6 : 3;
	endfunction

	// caller keeps idx below the keyword length
	function automatic logic [7:0] kw_char(input int k, input int idx);
		logic [47:0] txt;
		case (k)
			KW_RETURN: txt = "return";
			KW_RET:    txt = {"ret", 24'h0};
			default:   txt = {"int", 24'h0};
		endcase
		return txt[47-8*idx -: 8];
	endfunction

	task automatic add_token(input logic [KIND_BITS-1:0] kind, input logic [POS_BITS-1:0] start,
			input logic [POS_BITS:0] span_wide, input logic [KWI_BITS-1:0] kwi);
		result_t t;
		t.kind  = kind;
		t.start = start;
		t.span  = (span_wide > SPAN_MAX) ? SPAN_MAX : span_wide[SPAN_BITS-1:0];
		t.kwi   = kwi;
		t.last  = 1'b0;
		step_toks[step_n] = t;
		step_n++;
	endtask

	task automatic clear_scan();
		mode       = SCAN_IDLE;
		tok_start  = '0;
		last_digit = '0;
		pos        = '0;
		word_len   = '0;
		kw_hits    = '1;
	endtask

	// drop keywords that the word no longer matches as a prefix
	task automatic narrow_keywords(input logic [7:0] c, input int idx);
		for (int k = KW_RETURN; k < KW_NONE; k++) begin
			if (idx >= kw_length(k))
				kw_hits[k] = 1'b0;
			else if (kw_char(k, idx) != c)
				kw_hits[k] = 1'b0;
		end
	endtask

	task automatic close_token();
		logic [KWI_BITS-1:0] found;
		found = KW_NONE;
		case (mode)
			SCAN_INT: add_token(K_INT, tok_start, {1'b0, last_digit - tok_start} + 1, KW_NONE);
			SCAN_WORD: begin
				for (int k = KW_RETURN; k < KW_NONE; k++)
					if (found == KW_NONE && kw_hits[k] && word_len == kw_length(k))
						found = k[KWI_BITS-1:0];
				add_token(found == KW_NONE ? K_IDENT : K_KEYWORD, tok_start, word_len, found);
			end
			SCAN_COLON: add_token(K_COLON, tok_start, 1, KW_NONE);
			default: ;
		endcase
		mode = SCAN_IDLE;
	endtask

	task automatic open_token(input logic [7:0] c);
		if (is_space(c)) begin
		end else if (is_digit(c)) begin
			mode       = SCAN_INT;
			tok_start  = pos;
			last_digit = pos;
		end else if (is_alpha(c)) begin
			mode      = SCAN_WORD;
			tok_start = pos;
			word_len  = 1;
			kw_hits   = '1;
			narrow_keywords(c, 0);
		end else if (c == ":") begin
			mode      = SCAN_COLON;
			tok_start = pos;
		end else if (is_punct(c)) begin
			add_token(punct_kind(c), pos, 1, KW_NONE);
		end else begin
			add_token(K_BAD_CHAR, pos, 1, KW_NONE);
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
		logic    taken;
		result_t t;
		taken  = 1'b0;
		step_n = 0;
		if (eoi) begin
			close_token();
			add_token(K_EOF, pos, 0, KW_NONE);
			clear_scan();
		end else begin
			case (mode)
				SCAN_INT: begin
					if (is_digit(c)) begin
						last_digit = pos;
						taken = 1'b1;
					end else if (is_space(c)) begin
						taken = 1'b1;
					end else begin
						close_token();
					end
				end
				SCAN_WORD: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						narrow_keywords(c, word_len);
						if (word_len < SPAN_MAX)
							word_len++;
						taken = 1'b1;
					end else begin
						close_token();
					end
				end
				SCAN_COLON: begin
					if (c == ":" || c == "=") begin
						add_token(c == ":" ? K_COLON2 : K_ASSIGN, tok_start, 2, KW_NONE);
						mode = SCAN_IDLE;
						taken = 1'b1;
					end else begin
						close_token();
					end
				end
				default: ;
			endcase
			if (!taken)
				open_token(c);
			pos = pos + 1;
		end
		for (int i = 0; i < step_n; i++) begin
			t = step_toks[i];
			t.last = (i == step_n - 1);
			expected_tokens.push_back(t);
		end
	endtask

	task automatic check_token();
		result_t              want;
		logic [KIND_BITS-1:0] got_kind;
		logic [POS_BITS-1:0]  got_start;
		logic [SPAN_BITS-1:0] got_span;
		logic [KWI_BITS-1:0]  got_kwi;
		got_kind  = m_axis_tdata[KIND_BITS-1:0];
		got_start = m_axis_tdata[KIND_BITS +: POS_BITS];
		got_span  = m_axis_tdata[KIND_BITS+POS_BITS +: SPAN_BITS];
		got_kwi   = m_axis_tdata[KIND_BITS+POS_BITS+SPAN_BITS +: KWI_BITS];
		if (expected_tokens.size() == 0) begin
			$error("token with nothing expected: kind %0d start %0d span %0d",
				got_kind, got_start, got_span);
			mismatches++;
		end else begin
			want = expected_tokens.pop_front();
			tokens_checked++;
			if (got_kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got_kind);
				mismatches++;
			end
			if (got_start !== want.start) begin
				$error("start_res: expected %0d, got %0d", want.start, got_start);
				mismatches++;
			end
			if (got_span !== want.span) begin
				$error("span: expected %0d, got %0d", want.span, got_span);
				mismatches++;
			end
			if (got_kwi !== want.kwi) begin
				$error("keyword_index: expected %0d, got %0d", want.kwi, got_kwi);
				mismatches++;
			end
			if (m_axis_tlast !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			mismatches     = 0;
			tokens_checked = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				tokenize_byte(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				check_token();
		end
		pending = expected_tokens.size();
	end

endmodule

>>> test/tb_source_tokenizer.sv
// Testbench top for the source tokenizer: clock, reset, byte stimulus and verdict.
module tb_source_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;
	import stok_pkg::*;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = 8'd0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int mismatches;
	int tokens_pending;
	int tokens_checked;
	int idle_pct   = 36;
	int bytes_sent = 0;
	int ends_sent  = 0;

	always #5 clk = ~clk;

	source_tokenizer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	source_tokenizer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.pending        (tokens_pending),
		.tokens_checked (tokens_checked)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= eoi;
		do @(posedge clk); while (!s_axis_tready);
		if (eoi)
			ends_sent++;
		else
			bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// hold input off until every predicted token has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_space();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? 8'd32 : 8'd9 + r;
	endfunction

	function automatic logic [7:0] random_letter();
		return $urandom_range(1) ? 8'd97 + $urandom_range(25) : 8'd65 + $urandom_range(25);
	endfunction

	function automatic logic [7:0] random_punct();
		int r;
		r = $urandom_range(31);
		if (r < 15) return 8'd33 + r;
		if (r < 22) return 8'd58 + (r - 15);
		if (r < 28) return 8'd91 + (r - 22);
		return 8'd123 + (r - 28);
	endfunction

	// control bytes and the upper half of the byte range
	function automatic logic [7:0] random_bad_byte();
		int r;
		if ($urandom_range(1))
			return $urandom_range(128, 255);
		r = $urandom_range(27);
		if (r < 9) return r;
		if (r < 27) return r + 5;
		return 8'd127;
	endfunction

	task automatic send_random_token();
		int n;
		int r;
		r = $urandom_range(99);
		if (r < 18) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				send_byte(8'd48 + $urandom_range(9), 1'b0);
				if (i < n - 1 && $urandom_range(3) == 0)
					repeat ($urandom_range(1, 2)) send_byte(random_space(), 1'b0);
			end
		end else if (r < 38) begin
			case ($urandom_range(11))
				0: send_text("return");
				1: send_text("ret");
				2: send_text("int");
				3: send_text("re");
				4: send_text("retur");
				5: send_text("returns");
				6: send_text("in");
				7: send_text("integer");
				8: send_text("rett");
				9: send_text("Int");
				default: begin
					send_byte(random_letter(), 1'b0);
					repeat ($urandom_range(7)) begin
						case ($urandom_range(3))
							0: send_byte(8'd48 + $urandom_range(9), 1'b0);
							1: send_byte("_", 1'b0);
							default: send_byte(random_letter(), 1'b0);
						endcase
					end
				end
			endcase
		end else if (r < 60) begin
			send_byte(random_punct(), 1'b0);
		end else if (r < 68) begin
			case ($urandom_range(3))
				0: send_text("::");
				1: send_text(":=");
				2: send_text(":");
				default: send_text(":::");
			endcase
		end else if (r < 80) begin
			repeat ($urandom_range(1, 3)) send_byte(random_space(), 1'b0);
		end else if (r < 86) begin
			send_byte(random_bad_byte(), 1'b0);
		end else if (r < 94) begin
			send_byte($urandom_range(255), 1'b0);
		end else begin
			send_byte($urandom_range(255), 1'b1);
		end
	endtask

	initial begin
		int random_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// int with inner space, colon pairs, keywords, bad bytes, trailing colon at end
		send_text("7 0:=int::return");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("@;:");
		send_byte($urandom_range(255), 1'b1);
		drain();

		random_start = bytes_sent + ends_sent;
		while (bytes_sent + ends_sent < random_start + 1800) begin
			if ((bytes_sent + ends_sent - random_start) % 450 < 3 && $urandom_range(1))
				drain();
			idle_pct = (bytes_sent + ends_sent - random_start >= 800 &&
				bytes_sent + ends_sent - random_start < 1100) ? 0 : 36;
			send_random_token();
		end
		send_byte($urandom_range(255), 1'b1);
		idle_pct = 36;

		drain();
		repeat (10) @(posedge clk);
		$display("Covered %0d source bytes and %0d end markers, idling on both sides",
			bytes_sent, ends_sent);
		$display("with one stall-free stretch; %0d tokens compared with the predicted stream.",
			tokens_checked);
		if (mismatches == 0) begin
			$display("source_tokenizer test passed");
		end else begin
			$display("source_tokenizer test failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("source_tokenizer test failed");
		$finish;
	end

endmodule

>>> files.f
sv/stok_pkg.sv
sv/stok_scan.sv
sv/stok_outq.sv
sv/source_tokenizer.sv
test/source_tokenizer_checker.sv
test/tb_source_tokenizer.sv
